### sv/prim_mst_dense_macros.svh
// Assertion macros shared by the spanning tree RTL.
`ifndef PRIM_MST_DENSE_MACROS_SVH
`define PRIM_MST_DENSE_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset.
`define PMST_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Check that a condition never holds outside reset.
`define PMST_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define PMST_ASSERT(label, clk, rst_n, prop)
`define PMST_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

### sv/pmst_pkg.sv
// Types and constants for the dense-matrix spanning tree engine.
package pmst_pkg;

    localparam int ROW_W    = 5;
    localparam int COL_W    = 5;
    localparam int WEIGHT_W = 16;
    localparam int VCOUNT_W = 6;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_RUN  = 1'b1;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 6'd32;
    localparam int                  REG_VERTEX_COUNT = 0;

    // One input transfer
    typedef struct packed {
        logic                action;
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    col;
        logic [WEIGHT_W-1:0] weight;
    } t_cmd;

    // One result transfer
    typedef struct packed {
        logic [ROW_W-1:0]    child_vertex;
        logic [ROW_W-1:0]    parent_vertex;
        logic [WEIGHT_W-1:0] edge_weight;
        logic                reached;
        logic                last;
    } t_res;

    // Control from the sequencer to the relax unit
    typedef struct packed {
        logic clear;
        logic step;
        logic first;
    } t_relax_ctl;

endpackage

### sv/pmst_adj_ram.sv
// Adjacency weight memory: one shared read/write port, registered read.
module pmst_adj_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [DW-1:0] i_wdata,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write on load, read every cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/pmst_vtx_ram.sv
// Per-vertex key and parent memory: one write port, one registered read port.
module pmst_vtx_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int KW    = 17
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic          i_par_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [KW-1:0] i_wkey,
    input  logic [AW-1:0] i_wpar,
    input  logic [AW-1:0] i_raddr,
    output logic [KW-1:0] o_key,
    output logic [AW-1:0] o_par
);

    logic [KW-1:0] r_key_mem [DEPTH];
    logic [AW-1:0] r_par_mem [DEPTH];
    logic [KW-1:0] r_key;
    logic [AW-1:0] r_par;

    // Write key every step, parent only on a relaxed edge
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_key_mem[i_waddr] <= i_wkey;
        end
        if (i_we && i_par_we) begin
            r_par_mem[i_waddr] <= i_wpar;
        end
        r_key <= r_key_mem[i_raddr];
        r_par <= r_par_mem[i_raddr];
    end

    assign o_key = r_key;
    assign o_par = r_par;

endmodule

### sv/pmst_relax.sv
// Shared relax and compare unit with the running minimum tracker for the next pick.
module pmst_relax #(
    parameter int VW = 5,
    parameter int WB = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  pmst_pkg::t_relax_ctl   i_ctl,
    input  logic [VW-1:0]          i_idx,
    input  logic [WB-1:0]          i_w,
    input  logic [WB:0]            i_key,
    input  logic                   i_in_tree,
    output logic [WB:0]            o_key,
    output logic                   o_upd,
    output logic [VW-1:0]          o_pick
);
    import pmst_pkg::*;

    localparam logic [WB:0] KEY_INF = {1'b1, {WB{1'b0}}};

    logic [WB:0]   old_key;
    logic [WB:0]   new_key;
    logic          upd;
    logic [WB:0]   r_best_key;
    logic [VW-1:0] r_best_idx;
    logic [VW-1:0] r_fb_idx;
    logic          r_fb_found;

    // Relax one neighbor: keys start at infinity on the first pass
    always_comb begin
        old_key = i_ctl.first ? KEY_INF : i_key;
        upd     = (i_w != '0) && !i_in_tree && ({1'b0, i_w} < old_key);
        new_key = upd ? {1'b0, i_w} : old_key;
    end

    // Track lowest key and lowest unvisited index over the scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_best_key <= KEY_INF;
            r_fb_found <= 1'b0;
        end else if (i_ctl.step && !i_in_tree) begin
            if (!r_fb_found) begin
                r_fb_found <= 1'b1;
                r_fb_idx   <= i_idx;
            end
            if (new_key < r_best_key) begin
                r_best_key <= new_key;
                r_best_idx <= i_idx;
            end
        end
    end

    assign o_key  = new_key;
    assign o_upd  = upd;
    assign o_pick = r_best_key[WB] ? r_fb_idx : r_best_idx;

endmodule

### sv/prim_mst_dense.sv
// Top level: Prim spanning tree over a loaded dense weight matrix.
//
//  channel   direction  handshake                      payload
//  command   in         start high, busy low           i_cmd (pmst_pkg::t_cmd)
//  result    out        o_res_valid, one cycle, no stall  o_res (pmst_pkg::t_res)
//  config    in         psel & penable & pwrite       paddr, pwdata, prdata
//
// A load leaves busy low. A run over V vertices keeps busy high while each of
// the V-1 passes scans one adjacency row through the single RAM port and the
// one relax unit (V reads, then the registered RAM read, then the pick is
// taken), and the result scan then reads the V-1 keys. The last result shows
// in the same cycle that busy falls.
// Reset is synchronous, active low; the matrix memory is not cleared.
// Results cannot be stalled: each is shown for exactly one cycle.
`include "prim_mst_dense_macros.svh"

module prim_mst_dense #(
    parameter int MAX_NODES   = 32,
    parameter int WEIGHT_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  pmst_pkg::t_cmd i_cmd,
    output logic          o_res_valid,
    output pmst_pkg::t_res o_res,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import pmst_pkg::*;

    localparam int VW    = $clog2(MAX_NODES);
    localparam int CW    = VW + 1;
    localparam int KW    = WEIGHT_BITS + 1;
    localparam int AW    = $clog2(MAX_NODES * MAX_NODES);
    localparam int CAP   = (MAX_NODES < 32) ? MAX_NODES : 32;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RELAX,
        S_EMIT
    } t_state;

    t_state           r_state;
    logic [VCOUNT_W-1:0] r_vcount;
    logic [CW-1:0]    r_nv;
    logic [CW-1:0]    r_vi;
    logic [CW-1:0]    r_pass;
    logic             r_issue;
    logic             r_s1_v;
    logic [VW-1:0]    r_s1_idx;
    logic [VW-1:0]    r_u;
    logic             r_first;
    logic [MAX_NODES-1:0] r_in_tree;
    logic             r_res_valid;
    t_res             r_res;

    logic [VCOUNT_W:0] n_nvx;
    logic [CW-1:0]    n_nv;
    logic             cmd_take;
    logic             load_ok;
    logic             cfg_write;
    logic             pass_done;
    logic [AW-1:0]    adj_addr;
    logic [WEIGHT_BITS-1:0] adj_rdata;
    logic [KW-1:0]    vtx_key;
    logic [VW-1:0]    vtx_par;
    logic [KW-1:0]    rlx_key;
    logic             rlx_upd;
    logic [VW-1:0]    rlx_pick;
    t_relax_ctl       rlx_ctl;
    logic             emit_ok;

    // Command and configuration transfers
    assign busy      = (r_state != S_IDLE);
    assign cmd_take  = start && !busy;
    assign load_ok   = cmd_take && (i_cmd.action == ACT_LOAD)
                       && (32'(i_cmd.row) < MAX_NODES) && (32'(i_cmd.col) < MAX_NODES);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (32'(paddr[2]) == REG_VERTEX_COUNT) ? 32'(r_vcount) : 32'd0;

    // Clamp the vertex count into the supported range
    always_comb begin
        if (r_vcount == '0) begin
            n_nvx = 7'd1;
        end else if ({1'b0, r_vcount} > 7'(CAP)) begin
            n_nvx = 7'(CAP);
        end else begin
            n_nvx = {1'b0, r_vcount};
        end
        n_nv = CW'(n_nvx);
    end

    // Adjacency port: load address when idle, row scan during a pass
    always_comb begin
        if (r_state == S_IDLE) begin
            adj_addr = AW'(AW'(VW'(i_cmd.row)) * AW'(MAX_NODES) + AW'(VW'(i_cmd.col)));
        end else begin
            adj_addr = AW'(AW'(r_u) * AW'(MAX_NODES) + AW'(r_vi[VW-1:0]));
        end
    end

    pmst_adj_ram #(
        .DEPTH (MAX_NODES * MAX_NODES),
        .AW    (AW),
        .DW    (WEIGHT_BITS)
    ) u_adj (
        .i_clk   (i_clk),
        .i_we    (load_ok),
        .i_addr  (adj_addr),
        .i_wdata (WEIGHT_BITS'(i_cmd.weight)),
        .o_rdata (adj_rdata)
    );

    pmst_vtx_ram #(
        .DEPTH (MAX_NODES),
        .AW    (VW),
        .KW    (KW)
    ) u_vtx (
        .i_clk    (i_clk),
        .i_we     ((r_state == S_RELAX) && r_s1_v),
        .i_par_we (rlx_upd),
        .i_waddr  (r_s1_idx),
        .i_wkey   (rlx_key),
        .i_wpar   (r_u),
        .i_raddr  (r_vi[VW-1:0]),
        .o_key    (vtx_key),
        .o_par    (vtx_par)
    );

    // Pass ends once the last read has gone through the relax unit
    assign pass_done   = (r_state == S_RELAX) && !r_issue && !r_s1_v;
    assign rlx_ctl.clear = (r_state == S_IDLE) || pass_done;
    assign rlx_ctl.step  = (r_state == S_RELAX) && r_s1_v;
    assign rlx_ctl.first = r_first;

    pmst_relax #(
        .VW (VW),
        .WB (WEIGHT_BITS)
    ) u_relax (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (rlx_ctl),
        .i_idx     (r_s1_idx),
        .i_w       (adj_rdata),
        .i_key     (vtx_key),
        .i_in_tree (r_in_tree[r_s1_idx]),
        .o_key     (rlx_key),
        .o_upd     (rlx_upd),
        .o_pick    (rlx_pick)
    );

    assign emit_ok = ~vtx_key[KW-1];

    // Sequencer, configuration register and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vcount    <= VCOUNT_RESET;
            r_issue     <= 1'b0;
            r_s1_v      <= 1'b0;
            r_res_valid <= 1'b0;
            r_first     <= 1'b0;
            r_in_tree   <= '0;
            r_pass      <= '0;
            r_vi        <= '0;
            r_u         <= '0;
            r_nv        <= '0;
        end else begin
            r_res_valid <= 1'b0;
            if (cfg_write && (32'(paddr[2]) == REG_VERTEX_COUNT)) begin
                r_vcount <= pwdata[VCOUNT_W-1:0];
            end
            case (r_state)
                S_IDLE: begin
                    r_s1_v <= 1'b0;
                    if (cmd_take && (i_cmd.action == ACT_RUN)) begin
                        r_nv      <= n_nv;
                        r_in_tree <= MAX_NODES'(1);
                        r_u       <= '0;
                        r_pass    <= '0;
                        r_first   <= 1'b1;
                        r_vi      <= '0;
                        r_issue   <= (n_nv > CW'(1));
                        r_state   <= (n_nv > CW'(1)) ? S_RELAX : S_IDLE;
                    end
                end
                S_RELAX: begin
                    // Advance the row scan
                    r_s1_v   <= r_issue;
                    r_s1_idx <= r_vi[VW-1:0];
                    if (r_issue) begin
                        r_vi <= r_vi + CW'(1);
                        if (r_vi == r_nv - CW'(1)) begin
                            r_issue <= 1'b0;
                        end
                    end
                    if (pass_done) begin
                        r_first <= 1'b0;
                        r_issue <= 1'b1;
                        if (r_pass + CW'(1) == r_nv - CW'(1)) begin
                            r_vi    <= CW'(1);
                            r_state <= S_EMIT;
                        end else begin
                            r_vi               <= '0;
                            r_pass             <= r_pass + CW'(1);
                            r_u                <= rlx_pick;
                            r_in_tree[rlx_pick] <= 1'b1;
                        end
                    end
                end
                S_EMIT: begin
                    // Scan vertices 1..V-1 and send one result each
                    r_s1_v   <= r_issue;
                    r_s1_idx <= r_vi[VW-1:0];
                    if (r_issue) begin
                        r_vi <= r_vi + CW'(1);
                        if (r_vi == r_nv - CW'(1)) begin
                            r_issue <= 1'b0;
                        end
                    end
                    if (r_s1_v) begin
                        r_res_valid          <= 1'b1;
                        r_res.child_vertex   <= ROW_W'(r_s1_idx);
                        r_res.parent_vertex  <= emit_ok ? ROW_W'(vtx_par) : '0;
                        r_res.edge_weight    <= emit_ok ?
                                                WEIGHT_W'(vtx_key[WEIGHT_BITS-1:0]) : '0;
                        r_res.reached        <= emit_ok;
                        r_res.last           <= (CW'(r_s1_idx) == r_nv - CW'(1));
                        if (CW'(r_s1_idx) == r_nv - CW'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // Each pass adds exactly one new vertex to the tree
    `PMST_ASSERT(a_tree_count, i_clk, i_rst_n, (r_state == S_RELAX) |-> ($countones(r_in_tree) == int'(r_pass) + 1))
    // The final result of a run is not followed by another
    `PMST_ASSERT(a_last_ends, i_clk, i_rst_n, (o_res_valid && o_res.last) |=> !o_res_valid)
    // Vertex zero is the root and never reported
    `PMST_ASSERT_NEVER(a_child_nonzero, i_clk, i_rst_n, o_res_valid && (o_res.child_vertex == '0))

endmodule
